// ----- hw/rtl/tgs_pkg.sv -----
package tgs_pkg;

    // Fixed field and register widths
    localparam int SCALE_W     = 24;
    localparam int HOLD_W      = 16;
    localparam int ELAPSED_W   = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS  = 2'd1;

    // Register reset values
    localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 24'd200000;
    localparam logic [HOLD_W-1:0]  HOLDOFF_TICKS_RST  = 16'd500;

    // Measurement queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hw/rtl/tgs_in_if.sv -----
interface tgs_in_if;
    logic valid;
    logic ready;
    logic gate_a;
    logic gate_b;

    modport source (output valid, output gate_a, output gate_b, input ready);
    modport sink   (input valid, input gate_a, input gate_b, output ready);
endinterface

// ----- hw/rtl/tgs_out_if.sv -----
interface tgs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          direction;
    logic [tgs_pkg::ELAPSED_W-1:0] elapsed_ticks;
    logic [tgs_pkg::SCALE_W-1:0]   speed;

    modport source (output valid, output direction, output elapsed_ticks, output speed,
                    input ready);
    modport sink   (input valid, input direction, input elapsed_ticks, input speed,
                    output ready);
endinterface

// ----- hw/rtl/tgs_front.sv -----
module tgs_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_gate_a,
    input  logic                        i_gate_b,
    input  logic [tgs_pkg::HOLD_W-1:0]  i_holdoff_ticks,
    output logic                        o_push,
    output logic                        o_dir,
    output logic [TIME_WIDTH-1:0]       o_diff
);
    import tgs_pkg::*;

    logic [TIME_WIDTH-1:0] r_tick, n_tick;
    logic [TIME_WIDTH-1:0] r_stamp_a, n_stamp_a;
    logic [TIME_WIDTH-1:0] r_stamp_b, n_stamp_b;
    logic                  r_seen_a, n_seen_a;
    logic                  r_seen_b, n_seen_b;
    logic [HOLD_W-1:0]     r_holdoff_left, n_holdoff_left;

    // Stamps and flags after this tick's gate sample, before any clear
    logic [TIME_WIDTH-1:0] smp_stamp_a, smp_stamp_b;
    logic                  smp_seen_a, smp_seen_b;
    logic                  hit;

    always_comb begin
        smp_stamp_a = r_stamp_a;
        smp_stamp_b = r_stamp_b;
        smp_seen_a  = r_seen_a;
        smp_seen_b  = r_seen_b;
        if (i_gate_a) begin
            smp_stamp_a = r_tick;
            smp_seen_a  = 1'b1;
        end else if (i_gate_b) begin
            smp_stamp_b = r_tick;
            smp_seen_b  = 1'b1;
        end
    end

    assign hit    = smp_seen_a && smp_seen_b && (smp_stamp_a != smp_stamp_b);
    assign o_dir  = (smp_stamp_a > smp_stamp_b);
    assign o_diff = o_dir ? (smp_stamp_a - smp_stamp_b) : (smp_stamp_b - smp_stamp_a);

    always_comb begin
        n_tick         = r_tick;
        n_stamp_a      = r_stamp_a;
        n_stamp_b      = r_stamp_b;
        n_seen_a       = r_seen_a;
        n_seen_b       = r_seen_b;
        n_holdoff_left = r_holdoff_left;
        o_push         = 1'b0;
        if (i_accept) begin
            n_tick = r_tick + 1'b1;
            if (r_holdoff_left != '0) begin
                n_holdoff_left = r_holdoff_left - 1'b1;
            end else if (hit) begin
                // report, then clear and start the hold-off
                o_push         = 1'b1;
                n_stamp_a      = '0;
                n_stamp_b      = '0;
                n_seen_a       = 1'b0;
                n_seen_b       = 1'b0;
                n_holdoff_left = i_holdoff_ticks;
            end else begin
                n_stamp_a = smp_stamp_a;
                n_stamp_b = smp_stamp_b;
                n_seen_a  = smp_seen_a;
                n_seen_b  = smp_seen_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_stamp_a      <= '0;
            r_stamp_b      <= '0;
            r_seen_a       <= 1'b0;
            r_seen_b       <= 1'b0;
            r_holdoff_left <= '0;
        end else begin
            r_tick         <= n_tick;
            r_stamp_a      <= n_stamp_a;
            r_stamp_b      <= n_stamp_b;
            r_seen_a       <= n_seen_a;
            r_seen_b       <= n_seen_b;
            r_holdoff_left <= n_holdoff_left;
        end
    end

endmodule

// ----- hw/rtl/tgs_queue.sv -----
module tgs_queue #(
    parameter int WIDTH = 57
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output tgs_pkg::t_q_status o_status
);
    import tgs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/tgs_back.sv -----
module tgs_back #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic                           i_dir,
    input  logic [tgs_pkg::SCALE_W-1:0]    i_scale,
    input  logic [TIME_WIDTH-1:0]          i_diff,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_direction,
    output logic [tgs_pkg::ELAPSED_W-1:0]  o_elapsed,
    output logic [tgs_pkg::SCALE_W-1:0]    o_speed
);
    import tgs_pkg::*;

    // Remainder stays below 2^25 and below the divisor
    localparam int DW    = (TIME_WIDTH > SCALE_W + 1) ? TIME_WIDTH : SCALE_W + 1;
    localparam int CNT_W = $clog2(SCALE_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_back_state;

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW-1:0]     r_rem;
    logic [SCALE_W-1:0] r_quo;
    logic [TIME_WIDTH-1:0] r_div;
    logic              r_dir;

    logic [DW-1:0] rem_sh;
    logic [DW-1:0] div_ext;
    logic          fits;

    assign div_ext = DW'(r_div);
    assign rem_sh  = {r_rem[DW-2:0], r_quo[SCALE_W-1]};
    assign fits    = (rem_sh >= div_ext);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= CNT_W'(SCALE_W - 1);
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Restoring divider: one quotient bit per cycle, dividend shifts out of r_quo
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= '0;
            r_quo <= i_scale;
            r_div <= i_diff;
            r_dir <= i_dir;
        end else if (r_state == ST_DIV) begin
            r_rem <= fits ? (rem_sh - div_ext) : rem_sh;
            r_quo <= {r_quo[SCALE_W-2:0], fits};
        end
    end

    assign o_valid     = (r_state == ST_DONE);
    assign o_direction = r_dir;
    assign o_elapsed   = ELAPSED_W'(r_div);
    assign o_speed     = r_quo;

endmodule

// ----- hw/rtl/two_gate_speed_direction.sv -----
// Path: a measurement that an accepted tick completes is queued, then popped by the back end and
//   divided before it shows on the output (one queue pop, 24 divider steps).
// Throughput: one tick per cycle while the two-entry queue has room; the back end pops
//   no new measurement until the bit-serial restoring divider's result is taken.
// Reset: synchronous, active low; clears counter, stamps, flags, hold-off, queue
//   pointers and divider control; loads the register defaults (scale 200000, hold-off 500).
module two_gate_speed_direction #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tgs_in_if.sink                        i_in,
    tgs_out_if.source                     o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [tgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tgs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tgs_pkg::*;

    // Queue word layout: {direction, scale snapshot, elapsed}
    localparam int QW = 1 + SCALE_W + TIME_WIDTH;

    logic [SCALE_W-1:0] r_distance_scale;
    logic [HOLD_W-1:0]  r_holdoff_ticks;

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  front_dir;
    logic [TIME_WIDTH-1:0] front_diff;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;
    t_q_status             q_status;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_scale <= DISTANCE_SCALE_RST;
            r_holdoff_ticks  <= HOLDOFF_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DISTANCE_SCALE: r_distance_scale <= i_cfg_wdata[SCALE_W-1:0];
                REG_HOLDOFF_TICKS:  r_holdoff_ticks  <= i_cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a tick whenever the queue can hold a possible measurement;
    // any tick may complete one, so hold off only on a full queue.
    assign i_in.ready = !q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    // Front: tick counter, gate stamping, hold-off, measurement detect
    tgs_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_gate_a        (i_in.gate_a),
        .i_gate_b        (i_in.gate_b),
        .i_holdoff_ticks (r_holdoff_ticks),
        .o_push          (push),
        .o_dir           (front_dir),
        .o_diff          (front_diff)
    );

    // Snapshot the scale with each measurement so the back end is self-contained
    assign q_wdata = {front_dir, r_distance_scale, front_diff};

    tgs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (q_wdata),
        .i_pop    (pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    // Back: divide scale by elapsed ticks, hold the result until taken
    tgs_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_status.empty),
        .i_dir       (q_rdata[QW-1]),
        .i_scale     (q_rdata[QW-2:TIME_WIDTH]),
        .i_diff      (q_rdata[TIME_WIDTH-1:0]),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_direction (o_out.direction),
        .o_elapsed   (o_out.elapsed_ticks),
        .o_speed     (o_out.speed)
    );

`ifndef NO_ASSERTIONS
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("measurement pushed into full queue");

    // A measurement clears both flags, so the next tick cannot complete another
    a_no_double_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !push)
        else $error("two measurements on consecutive ticks");

    // The back end pops only while no result is pending on the output
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !o_out.valid)
        else $error("queue popped while a result is pending");
`endif

endmodule
